/* rtl/evpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder volume and power control package
// Shared types, register indexes and reset values.
// ----------------------------------------------------------------------------
package evpc_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int VOL_W           = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STORE_DELAY = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd50;
    localparam logic [CFG_W-1:0] HOLD_LIMIT_RST  = 16'd2000;
    localparam logic [CFG_W-1:0] STORE_DELAY_RST = 16'd1000;

    localparam logic [VOL_W-1:0] VOL_MAX = 8'd255;
    localparam logic [VOL_W-1:0] VOL_MIN = 8'd0;

    localparam logic CMD_PIN  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic command;
        logic phase_a;
        logic phase_b;
        logic button_level;
    } in_t;

    typedef struct packed {
        logic             power_active;
        logic             relay_on;
        logic [VOL_W-1:0] volume_level;
        logic             store_pending;
        logic             store_triggered;
        logic             hold_power_off;
    } out_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] hold_limit_ticks;
        logic [CFG_W-1:0] store_delay_ticks;
    } cfg_t;

endpackage

/* rtl/encoder_volume_power_control_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder volume and power control
// Rotary encoder volume stepping, button power and relay control, and
// long-press power off, driven by pin-change and timer-tick items.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    in_data (evpc_pkg::in_t)
// out      output     out_valid / out_stall  out_data (evpc_pkg::out_t)
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// One item is accepted per cycle while in_stall is low; its result is then offered from the result register.
// The input register feeds the state update, which writes the result register.
// Reset clears the state and loads the register defaults.
// A stalled result holds; the input register still takes one more item.
// ----------------------------------------------------------------------------
module encoder_volume_power_control_top #(
    parameter int COUNT_WIDTH = evpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  evpc_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output evpc_pkg::out_t                     out_data,
    input  logic                               cfg_we,
    input  logic [evpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [evpc_pkg::CFG_W-1:0]         cfg_data
);
    import evpc_pkg::*;

    cfg_t cfg_reg;
    in_t  in_data_reg;
    logic in_vld_reg;
    out_t out_data_reg;
    logic out_vld_reg;
    out_t result;
    logic advance;

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;

    evpc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_data_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks    <= DEBOUNCE_RST;
            cfg_reg.hold_limit_ticks  <= HOLD_LIMIT_RST;
            cfg_reg.store_delay_ticks <= STORE_DELAY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE:    cfg_reg.debounce_ticks    <= cfg_data;
                REG_HOLD_LIMIT:  cfg_reg.hold_limit_ticks  <= cfg_data;
                REG_STORE_DELAY: cfg_reg.store_delay_ticks <= cfg_data;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_lp_off_drops_all: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_data_reg.hold_power_off
        |-> !out_data_reg.power_active && !out_data_reg.relay_on)
        else $error("long-press power off left power or relay on");

    a_relay_needs_power: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_data_reg.power_active |-> !out_data_reg.relay_on)
        else $error("relay on while power is off");

    a_trig_excl_lp: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_data_reg.store_triggered |-> !out_data_reg.hold_power_off)
        else $error("one item both stepped volume and powered off");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg && out_vld_reg && out_stall)
        else $error("input stalled with room in the pipeline");

    a_advance_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("result register not loaded after advance");
`endif

endmodule

/* rtl/evpc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder volume and power control core
// Holds the control state and applies one item to it per step.
// ----------------------------------------------------------------------------
module evpc_core #(
    parameter int COUNT_WIDTH = evpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  evpc_pkg::in_t   item,
    input  evpc_pkg::cfg_t  cfg,
    output evpc_pkg::out_t  result
);
    import evpc_pkg::*;

    localparam int HOLD_W = COUNT_WIDTH + 1;
    localparam int CMP_W  = (HOLD_W > CFG_W) ? HOLD_W : CFG_W;

    logic                   power_reg, power_next;
    logic                   relay_reg, relay_next;
    logic [VOL_W-1:0]       volume_reg, volume_next;
    logic [COUNT_WIDTH-1:0] deb_reg, deb_next;
    logic [COUNT_WIDTH-1:0] store_reg, store_next;
    logic [HOLD_W-1:0]      hold_reg, hold_next;
    logic                   trig;
    logic                   lp_off;

    always_comb
    begin
        power_next  = power_reg;
        relay_next  = relay_reg;
        volume_next = volume_reg;
        deb_next    = deb_reg;
        store_next  = store_reg;
        hold_next   = hold_reg;
        trig        = 1'b0;
        lp_off      = 1'b0;
        if (item.command == CMD_PIN)
        begin
            if (deb_reg == '0)
            begin
                if (!item.phase_a && power_reg)
                begin
                    if (!item.phase_b)
                    begin
                        if (volume_reg != VOL_MIN)
                        begin
                            volume_next = volume_reg - 8'd1;
                        end
                    end
                    else if (volume_reg != VOL_MAX)
                    begin
                        volume_next = volume_reg + 8'd1;
                    end
                    store_next = COUNT_WIDTH'(cfg.store_delay_ticks);
                    trig       = 1'b1;
                end
                if (!item.button_level)
                begin
                    if (!power_reg)
                    begin
                        power_next = 1'b1;
                    end
                    else
                    begin
                        relay_next = ~relay_reg;
                    end
                end
                deb_next = COUNT_WIDTH'(cfg.debounce_ticks);
            end
        end
        else
        begin
            if (deb_reg != '0)
            begin
                deb_next = deb_reg - COUNT_WIDTH'(1);
            end
            if (store_reg != '0)
            begin
                store_next = store_reg - COUNT_WIDTH'(1);
            end
            if (power_reg)
            begin
                if (!item.button_level)
                begin
                    if (hold_reg != '1)
                    begin
                        hold_next = hold_reg + HOLD_W'(1);
                    end
                end
                else
                begin
                    hold_next = '0;
                end
                if (CMP_W'(hold_next) > CMP_W'(cfg.hold_limit_ticks))
                begin
                    power_next = 1'b0;
                    relay_next = 1'b0;
                    hold_next  = '0;
                    lp_off     = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        result.power_active    = power_next;
        result.relay_on        = relay_next;
        result.volume_level    = volume_next;
        result.store_pending   = (store_next != '0);
        result.store_triggered = trig;
        result.hold_power_off  = lp_off;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg  <= 1'b0;
            relay_reg  <= 1'b0;
            volume_reg <= '0;
            deb_reg    <= '0;
            store_reg  <= '0;
            hold_reg   <= '0;
        end
        else if (step)
        begin
            power_reg  <= power_next;
            relay_reg  <= relay_next;
            volume_reg <= volume_next;
            deb_reg    <= deb_next;
            store_reg  <= store_next;
            hold_reg   <= hold_next;
        end
    end

endmodule

/* verif/evpc_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder volume and power control checker
// Tracks the register settings and the control state of the block. For every
// accepted item it queues the result that the block must return, and it
// compares each returned result with the oldest queued one, field by field.
// ----------------------------------------------------------------------------
package evpc_tb_pkg;

    import evpc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [CFG_W-1:0]     TICKS_MAX  = '1;

    class control_scoreboard;

        logic [CFG_W-1:0]           debounce_ticks;
        logic [CFG_W-1:0]           hold_limit_ticks;
        logic [CFG_W-1:0]           store_delay_ticks;
        logic                       power;
        logic                       relay;
        logic [VOL_W-1:0]           volume;
        logic [COUNT_WIDTH_DEF-1:0] debounce_count;
        logic [COUNT_WIDTH_DEF-1:0] store_count;
        logic [COUNT_WIDTH_DEF:0]   hold_count;
        out_t                       expected_outputs[$];
        int unsigned                errors;

        function new();
            debounce_ticks    = DEBOUNCE_RST;
            hold_limit_ticks  = HOLD_LIMIT_RST;
            store_delay_ticks = STORE_DELAY_RST;
            power             = 1'b0;
            relay             = 1'b0;
            volume            = '0;
            debounce_count    = '0;
            store_count       = '0;
            hold_count        = '0;
            errors            = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
            case (index)
                REG_DEBOUNCE:    debounce_ticks    = value;
                REG_HOLD_LIMIT:  hold_limit_ticks  = value;
                REG_STORE_DELAY: store_delay_ticks = value;
                default: ;
            endcase
        endfunction

        function void note_item(in_t item);
            out_t want;
            want = '0;
            if (item.command == CMD_PIN) begin
                if (debounce_count == 0) begin
                    if (!item.phase_a && power) begin
                        if (!item.phase_b) begin
                            if (volume != VOL_MIN)
                                volume--;
                        end
                        else if (volume != VOL_MAX) begin
                            volume++;
                        end
                        store_count = COUNT_WIDTH_DEF'(store_delay_ticks);
                        want.store_triggered = 1'b1;
                    end
                    if (!item.button_level) begin
                        if (!power)
                            power = 1'b1;
                        else
                            relay = ~relay;
                    end
                    debounce_count = COUNT_WIDTH_DEF'(debounce_ticks);
                end
            end
            else begin
                if (debounce_count != 0)
                    debounce_count--;
                if (store_count != 0)
                    store_count--;
                if (power) begin
                    if (!item.button_level) begin
                        if (hold_count != '1)
                            hold_count++;
                    end
                    else begin
                        hold_count = '0;
                    end
                    if (hold_count > hold_limit_ticks) begin
                        power               = 1'b0;
                        relay               = 1'b0;
                        hold_count          = '0;
                        want.hold_power_off = 1'b1;
                    end
                end
            end
            want.power_active  = power;
            want.relay_on      = relay;
            want.volume_level  = volume;
            want.store_pending = (store_count != 0);
            expected_outputs.push_back(want);
        endfunction

        function void check_field(string name, logic [VOL_W-1:0] want, logic [VOL_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (expected_outputs.size() == 0) begin
                errors++;
                $display("%0t: result with no item waiting: expected none, actual %h", $time, got);
                return;
            end
            want = expected_outputs.pop_front();
            check_field("power_active", VOL_W'(want.power_active),
                        VOL_W'(got.power_active));
            check_field("relay_on", VOL_W'(want.relay_on), VOL_W'(got.relay_on));
            check_field("volume_level", want.volume_level, got.volume_level);
            check_field("store_pending", VOL_W'(want.store_pending),
                        VOL_W'(got.store_pending));
            check_field("store_triggered", VOL_W'(want.store_triggered),
                        VOL_W'(got.store_triggered));
            check_field("hold_power_off", VOL_W'(want.hold_power_off),
                        VOL_W'(got.hold_power_off));
        endfunction

    endclass

endpackage

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder volume and power control testbench
// Drives pin-change and tick items with random gaps and output stalls, walks
// the register settings through small values and both extremes, and checks
// every result against an independent prediction of the control state.
// ----------------------------------------------------------------------------
module tb_top;

    import evpc_pkg::*;
    import evpc_tb_pkg::*;

    typedef enum int { MIX_GENERAL, MIX_SWEEP_UP, MIX_SWEEP_DOWN } stim_mix_e;

    localparam int IDLE_LIMIT     = 2000;
    localparam int HOLDOFF_AT     = 300;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int ITEM_TARGET    = 1800;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_t                  in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_t                 out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    control_scoreboard scoreboard;
    int unsigned       items_sent   = 0;
    int unsigned       results_seen = 0;
    int unsigned       idle_cycles  = 0;
    int unsigned       hold_left    = 0;
    int unsigned       stall_left   = 0;
    bit                rx_steady    = 1'b0;

    encoder_volume_power_control_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            scoreboard.check_result(out_data);
            results_seen++;
            if (results_seen % 64 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
            if (results_seen == HOLDOFF_AT)
                stall_left = HOLDOFF_CYCLES;
            else
                stall_left = rx_steady ? 0 : $urandom_range(0, 4);
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic in_t make_item(logic cmd, logic pa, logic pb, logic btn);
        in_t item;
        item.command      = cmd;
        item.phase_a      = pa;
        item.phase_b      = pb;
        item.button_level = btn;
        return item;
    endfunction

    function automatic logic [CFG_W-1:0] pick_ticks(int zero_pct, int max_pct, int top);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < zero_pct)
            return '0;
        if (roll < zero_pct + max_pct)
            return TICKS_MAX;
        return CFG_W'($urandom_range(1, top));
    endfunction

    task automatic send_item(input in_t item, input bit steady);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        scoreboard.note_item(item);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (scoreboard.expected_outputs.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        scoreboard.write_reg(index, value);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] debounce,
                              input logic [CFG_W-1:0] hold_limit,
                              input logic [CFG_W-1:0] store_delay);
        write_reg(REG_DEBOUNCE, debounce);
        write_reg(REG_HOLD_LIMIT, hold_limit);
        write_reg(REG_STORE_DELAY, store_delay);
        cfg_we <= 1'b0;
    endtask

    task automatic run_mix(input stim_mix_e mix, input int count);
        int  pin_pct;
        int  pa_high_pct;
        int  up_pct;
        int  press_pct;
        int  hold_pct;
        bit  steady;
        in_t item;
        steady = ($urandom_range(0, 3) == 0);
        case (mix)
            MIX_SWEEP_UP:
            begin
                pin_pct = 85; pa_high_pct = 5; up_pct = 97; press_pct = 2; hold_pct = 0;
            end
            MIX_SWEEP_DOWN:
            begin
                pin_pct = 85; pa_high_pct = 5; up_pct = 3; press_pct = 2; hold_pct = 0;
            end
            default:
            begin
                pin_pct = 40; pa_high_pct = 30; up_pct = $urandom_range(20, 80);
                press_pct = 10; hold_pct = 8;
            end
        endcase
        repeat (count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                item = 4'($urandom_range(0, 15));
            end
            else
            begin
                item.command = ($urandom_range(0, 99) < pin_pct) ? CMD_PIN : CMD_TICK;
                item.phase_a = ($urandom_range(0, 99) < pa_high_pct);
                item.phase_b = ($urandom_range(0, 99) < up_pct);
                if (hold_left == 0 && $urandom_range(0, 99) < hold_pct)
                    hold_left = $urandom_range(1, 25);
                if (hold_left > 0)
                begin
                    item.button_level = 1'b0;
                    hold_left--;
                end
                else
                begin
                    item.button_level = ($urandom_range(0, 99) >= press_pct);
                end
            end
            send_item(item, steady);
        end
    endtask

    initial
    begin
        stim_mix_e mix;
        int        phase_no;
        int        left;
        int        count;
        scoreboard = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Power-off tick, power-on press with the default debounce, then a
        // press that the debounce window swallows.
        send_item(make_item(CMD_TICK, 1'b1, 1'b1, 1'b1), 1'b0);
        send_item(make_item(CMD_PIN, 1'b0, 1'b0, 1'b0), 1'b0);
        send_item(make_item(CMD_PIN, 1'b0, 1'b1, 1'b0), 1'b0);
        while (scoreboard.debounce_count != 0)
            send_item(make_item(CMD_TICK, 1'b1, 1'b0, 1'b1), 1'b0);
        wait_idle();
        write_reg(REG_DEBOUNCE, '0);
        cfg_we <= 1'b0;

        // Step down at zero, step up, relay toggles, and a hold in progress.
        send_item(make_item(CMD_PIN, 1'b0, 1'b0, 1'b1), 1'b0);
        send_item(make_item(CMD_PIN, 1'b0, 1'b1, 1'b1), 1'b0);
        send_item(make_item(CMD_PIN, 1'b1, 1'b1, 1'b0), 1'b0);
        send_item(make_item(CMD_PIN, 1'b0, 1'b1, 1'b0), 1'b0);
        send_item(make_item(CMD_TICK, 1'b0, 1'b0, 1'b0), 1'b0);
        send_item(make_item(CMD_TICK, 1'b1, 1'b0, 1'b0), 1'b0);
        wait_idle();
        write_reg(REG_HOLD_LIMIT, 16'd1);
        write_reg(REG_STORE_DELAY, '0);
        cfg_we <= 1'b0;

        // The lowered limit ends the hold at once; then ticks and presses
        // with the power off, and a step with a zero store delay.
        send_item(make_item(CMD_TICK, 1'b0, 1'b1, 1'b0), 1'b0);
        send_item(make_item(CMD_TICK, 1'b0, 1'b0, 1'b0), 1'b0);
        send_item(make_item(CMD_PIN, 1'b0, 1'b0, 1'b1), 1'b0);
        send_item(make_item(CMD_PIN, 1'b1, 1'b0, 1'b0), 1'b0);
        send_item(make_item(CMD_PIN, 1'b0, 1'b0, 1'b1), 1'b0);
        send_item(make_item(CMD_TICK, 1'b1, 1'b1, 1'b1), 1'b0);
        send_item(make_item(CMD_TICK, 1'b0, 1'b1, 1'b0), 1'b0);
        send_item(make_item(CMD_TICK, 1'b1, 1'b0, 1'b0), 1'b0);
        wait_idle();
        write_reg(REG_HOLD_LIMIT, '0);
        write_reg(REG_STORE_DELAY, 16'd3);
        write_reg(REG_UNUSED, CFG_W'($urandom));
        cfg_we <= 1'b0;

        // A zero limit powers off on the first held tick. A press with the
        // power off must not step the volume before turning the power on.
        send_item(make_item(CMD_PIN, 1'b1, 1'b1, 1'b0), 1'b0);
        send_item(make_item(CMD_TICK, 1'b1, 1'b1, 1'b0), 1'b0);
        send_item(make_item(CMD_PIN, 1'b0, 1'b0, 1'b0), 1'b0);
        send_item(make_item(CMD_PIN, 1'b0, 1'b1, 1'b1), 1'b0);

        phase_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase_no % 4)
                1:       mix = MIX_SWEEP_UP;
                3:       mix = MIX_SWEEP_DOWN;
                default: mix = MIX_GENERAL;
            endcase
            wait_idle();
            left  = ITEM_TARGET - int'(items_sent);
            count = (mix == MIX_GENERAL) ? int'($urandom_range(100, 200)) : 400;
            if (count > left)
                count = left;
            if (mix == MIX_GENERAL)
            begin
                set_config(pick_ticks(40, 0, 6), pick_ticks(15, 10, 20), pick_ticks(20, 10, 12));
                run_mix(mix, count);
            end
            else
            begin
                set_config('0, CFG_W'($urandom_range(5, 20)), pick_ticks(20, 10, 12));
                run_mix(mix, count);
            end
            phase_no++;
        end

        wait_idle();
        set_config(TICKS_MAX, TICKS_MAX, TICKS_MAX);
        run_mix(MIX_GENERAL, 40);

        wait_idle();
        repeat (8) @(posedge clk);
        if (scoreboard.errors == 0 && scoreboard.expected_outputs.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
rtl/evpc_pkg.sv
rtl/evpc_core.sv
rtl/encoder_volume_power_control_top.sv
verif/evpc_tb_pkg.sv
verif/tb_top.sv
